### hdl/pedd_pkg.sv
// shared types and constants for the palette error diffusion dither
package pedd_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_LINE_WIDTH     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PALETTE_COUNT  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PALETTE_PAIR_0 = 3'd2;
  localparam int unsigned PairCount = 6;
  localparam int unsigned CfgDataW = 48;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [3:0] palette_index;
  } pix_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

### hdl/pedd_stream_if.sv
// valid/ready channel carrying one payload
interface pedd_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/palette_error_diffusion_dither.sv
// top level of the palette error diffusion dither
//  channel | dir | payload
//  in_     | in  | pix_in_t: rgb, alpha, frame_start
//  out_    | out | pix_out_t: palette rgb, alpha, index
//  cfg_    | in  | cfg_wr_t: register index, 48-bit data
// the result follows the in transaction through read, adjust, a search over each entry
// in turn through one squared-distance unit, and write-back of the previous and current columns
// a new in transaction is taken only after the last result is written back and taken on out
// a frame_start pixel, and reset, first clear all MAX_WIDTH entries of the error memory
// rst_n is synchronous; in ready is low while busy or while a result waits on out
// configuration writes are always taken
module palette_error_diffusion_dither #(
  parameter int MAX_WIDTH = 1024,
  parameter int PALETTE_ENTRIES = 12,
  parameter int ERROR_FRACTION_BITS = 4
) (
  input logic clk,
  input logic rst_n,
  pedd_stream_if.sink   in_ch,
  pedd_stream_if.source out_ch,
  pedd_stream_if.sink   cfg_ch
);
  import pedd_pkg::*;

  localparam int F  = ERROR_FRACTION_BITS;
  localparam int EW = 9 + F;           // saturated error width
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = AW + 1;
  localparam logic signed [EW-1:0] ETOP = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] EBOT = {1'b1, {(EW-1){1'b0}}};

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_READ = 7'b0000100,
    S_ADJ = 7'b0001000, S_SRCH = 7'b0010000, S_WBL = 7'b0100000,
    S_WCUR = 7'b1000000
  } state_t;

  state_t state_r;
  logic [10:0] width_r;
  logic [3:0]  count_r;
  logic [47:0] pair_r [PairCount];
  logic [3*EW-1:0] mem [MAX_WIDTH];
  logic [3*EW-1:0] rd_r;
  logic [AW-1:0] clr_r;
  logic [CW-1:0] col_r;
  logic signed [EW-1:0] rc_r [3], bl_r [3], e_r [3];
  logic [F+7:0] adj_r [3];
  pix_in_t pix_r;
  logic [3:0] idx_r, best_r;
  logic [17:0] bd_r;
  logic [23:0] brgb_r;
  logic ovalid_r;
  pix_out_t out_r;
  logic last_r;

  // effective width and count
  logic [CW-1:0] w_eff;
  logic [3:0] n_eff;
  always_comb begin
    if (width_r == 11'd0) w_eff = CW'(1);
    else if ({21'd0, width_r} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_r);
    if (count_r == 4'd0) n_eff = 4'd1;
    else if ({28'd0, count_r} > 32'(PALETTE_ENTRIES)) n_eff = 4'(PALETTE_ENTRIES);
    else n_eff = count_r;
  end

  // palette entry under the search pointer
  logic [47:0] cur_pair;
  logic [23:0] cur_rgb;
  always_comb begin
    cur_pair = pair_r[idx_r[3:1]];
    cur_rgb = idx_r[0] ? cur_pair[47:24] : cur_pair[23:0];
  end

  // shared distance unit
  logic signed [9:0] dr, dg, db;
  logic [17:0] sq_dist;
  always_comb begin
    dr = $signed({2'b0, adj_r[0][F+7:F]}) - $signed({2'b0, cur_rgb[23:16]});
    dg = $signed({2'b0, adj_r[1][F+7:F]}) - $signed({2'b0, cur_rgb[15:8]});
    db = $signed({2'b0, adj_r[2][F+7:F]}) - $signed({2'b0, cur_rgb[7:0]});
    sq_dist = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);
  end

  function automatic logic signed [EW+3:0] weigh(logic signed [EW-1:0] e, int w);
    logic signed [EW+3:0] p;
    p = (EW+4)'(e) * (EW+4)'(w);
    return p >>> 4;
  endfunction

  function automatic logic signed [EW-1:0] sat(logic signed [EW+4:0] v);
    if (v > (EW+5)'(ETOP)) return ETOP;
    if (v < (EW+5)'(EBOT)) return EBOT;
    return EW'(v);
  endfunction

  function automatic logic [F+8:0] in_pix_ch(int k);
    logic [7:0] c;
    case (k)
      0: c = pix_r.red_in;
      1: c = pix_r.green_in;
      default: c = pix_r.blue_in;
    endcase
    return {1'b0, c, {F{1'b0}}};
  endfunction

  // adjusted channels
  logic [F+7:0] adj_c [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [EW+2:0] v;
      v = $signed({3'b0, in_pix_ch(k)}) + (EW+3)'($signed(rd_r[k*EW +: EW]))
          + (EW+3)'(rc_r[k]);
      if (v < 0) adj_c[k] = '0;
      else if (v > (EW+3)'({1'b0, {(F+8){1'b1}}})) adj_c[k] = '1;
      else adj_c[k] = (F+8)'(v);
    end
  end

  // error of each channel against the chosen entry
  logic signed [EW-1:0] e_c [3];
  always_comb begin
    e_c[0] = $signed({1'b0, adj_r[0]}) - $signed({1'b0, brgb_r[23:16], {F{1'b0}}});
    e_c[1] = $signed({1'b0, adj_r[1]}) - $signed({1'b0, brgb_r[15:8], {F{1'b0}}});
    e_c[2] = $signed({1'b0, adj_r[2]}) - $signed({1'b0, brgb_r[7:0], {F{1'b0}}});
  end

  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ovalid_r;
  assign out_ch.payload = out_r;

  logic [AW-1:0] col_a, col_m1;
  assign col_a = col_r[AW-1:0];
  assign col_m1 = col_a - AW'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 11'd1024;
      count_r <= 4'd2;
      for (int i = 1; i < PairCount; i++) pair_r[i] <= '0;
      pair_r[0] <= 48'hFFFFFF000000;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.payload.index == REG_LINE_WIDTH) width_r <= cfg_ch.payload.data[10:0];
      else if (cfg_ch.payload.index == REG_PALETTE_COUNT) count_r <= cfg_ch.payload.data[3:0];
      else pair_r[cfg_ch.payload.index - REG_PALETTE_PAIR_0] <= cfg_ch.payload.data;
    end
  end

  // error line memory
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) mem[clr_r] <= '0;
    else if (state_r == S_WBL) begin
      if (col_r != '0)
        mem[col_m1] <= {sat((EW+5)'($signed(rd_r[2*EW +: EW])) + (EW+5)'(weigh(e_c[2], 3))),
                        sat((EW+5)'($signed(rd_r[EW +: EW])) + (EW+5)'(weigh(e_c[1], 3))),
                        sat((EW+5)'($signed(rd_r[0 +: EW])) + (EW+5)'(weigh(e_c[0], 3)))};
    end else if (state_r == S_WCUR)
      mem[col_a] <= {sat((EW+5)'(bl_r[2]) + (EW+5)'(weigh(e_r[2], 5))),
                     sat((EW+5)'(bl_r[1]) + (EW+5)'(weigh(e_r[1], 5))),
                     sat((EW+5)'(bl_r[0]) + (EW+5)'(weigh(e_r[0], 5)))};
    if (state_r == S_READ) rd_r <= mem[col_a];
    else if (state_r == S_SRCH && idx_r == n_eff - 4'd1 && col_r != '0) rd_r <= mem[col_m1];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      col_r <= '0;
      ovalid_r <= 1'b0;
      pix_r <= '0;
      for (int k = 0; k < 3; k++) begin
        rc_r[k] <= '0;
        bl_r[k] <= '0;
      end
    end else begin
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(MAX_WIDTH - 1)) state_r <= pix_r.frame_start ? S_READ : S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && !ovalid_r) begin
            pix_r <= in_ch.payload;
            if (in_ch.payload.frame_start) begin
              col_r <= '0;
              clr_r <= '0;
              for (int k = 0; k < 3; k++) begin
                rc_r[k] <= '0;
                bl_r[k] <= '0;
              end
              state_r <= S_CLEAR;
            end else state_r <= S_READ;
          end
        end
        S_READ: begin
          if (col_r >= CW'(MAX_WIDTH)) col_r <= CW'(MAX_WIDTH - 1);
          else state_r <= S_ADJ;
        end
        S_ADJ: begin
          for (int k = 0; k < 3; k++) adj_r[k] <= adj_c[k];
          last_r <= (col_r + CW'(1)) >= w_eff;
          idx_r <= '0;
          state_r <= S_SRCH;
        end
        S_SRCH: begin
          if (idx_r == '0 || sq_dist < bd_r) begin
            bd_r <= sq_dist;
            best_r <= idx_r;
            brgb_r <= cur_rgb;
          end
          if (idx_r == n_eff - 4'd1) state_r <= S_WBL;
          idx_r <= idx_r + 4'd1;
        end
        S_WBL: begin
          for (int k = 0; k < 3; k++) e_r[k] <= e_c[k];
          state_r <= S_WCUR;
        end
        default: begin
          for (int k = 0; k < 3; k++) begin
            bl_r[k] <= last_r ? '0 : EW'(weigh(e_r[k], 1));
            rc_r[k] <= last_r ? '0 : EW'(weigh(e_r[k], 7));
          end
          col_r <= last_r ? '0 : col_r + CW'(1);
          out_r <= '{red_out: brgb_r[23:16], green_out: brgb_r[15:8],
                     blue_out: brgb_r[7:0], alpha_out: pix_r.alpha_in,
                     palette_index: best_r};
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // protocol and range checks
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WCUR) |=> ovalid_r) else $error("result not raised");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE) else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= CW'(MAX_WIDTH)) else $error("column overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> idx_r < n_eff) else $error("search past count");
endmodule
